FILE: design/em_afe_pkg.sv
`default_nettype none
package em_afe_pkg;

  localparam int unsigned MAX_INDIVIDUALS = 1024;
  localparam int unsigned ADDR_W  = $clog2(MAX_INDIVIDUALS);
  localparam int unsigned CNT_W   = ADDR_W + 1;
  localparam int unsigned ENTRY_W = 48;
  localparam int unsigned LIK_W   = 16;
  localparam int unsigned FREQ_W  = 16;
  localparam int unsigned ITER_W  = 8;
  localparam int unsigned TAG_W   = 16;
  localparam int unsigned CFG_W   = 16;

  // long divider: dividend, divisor and step count widths
  localparam int unsigned DIV_NW = 28;
  localparam int unsigned DIV_DW = CNT_W + 1;
  localparam int unsigned DIV_CW = $clog2(DIV_NW + 1);

  // term unit: shared multiplier, product and numerator/denominator widths
  localparam int unsigned MUL_AW = 33;
  localparam int unsigned MUL_BW = 17;
  localparam int unsigned PROD_W = MUL_AW + MUL_BW;
  localparam int unsigned TERM_W = 52;

  typedef enum logic {
    REG_TOLERANCE = 1'b0,
    REG_MAX_ITER  = 1'b1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    S_LOAD,
    S_PSTART,
    S_PWAIT,
    S_CHECK,
    S_COEF,
    S_RD,
    S_ISTART,
    S_IWAIT,
    S_MSTART,
    S_MWAIT,
    S_DONE
  } st_e;

  typedef enum logic [2:0] {
    T_IDLE,
    T_COEF,
    T_MUL,
    T_SUM,
    T_DIV
  } term_st_e;

  typedef struct packed {
    logic coef;   // compute p*p, p*q, q*q for the pass
    logic item;   // compute one individual's term
  } term_cmd_t;

  typedef struct packed {
    logic                done;
    logic [FREQ_W-1:0]   term;
  } term_sts_t;

  function automatic logic [FREQ_W-1:0] sat16(input logic [DIV_NW-1:0] v);
    logic [FREQ_W-1:0] r;
    if (v[DIV_NW-1:FREQ_W] != '0) r = '1;
    else r = v[FREQ_W-1:0];
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: design/em_afe_ram.sv
`default_nettype none
module em_afe_ram #(
  parameter int unsigned Width = 48,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

FILE: design/em_afe_div.sv
`default_nettype none
// Restoring long divider, one quotient bit per cycle. Divisor zero gives zero.
module em_afe_div (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic [em_afe_pkg::DIV_NW-1:0]  dividend_i,
  input  wire logic [em_afe_pkg::DIV_DW-1:0]  divisor_i,
  output logic                                done_o,
  output logic      [em_afe_pkg::DIV_NW-1:0]  quot_o
);

  logic                          busy_q;
  logic                          done_q;
  logic [em_afe_pkg::DIV_CW-1:0] cnt_q;
  logic [em_afe_pkg::DIV_DW-1:0] rem_q;
  logic [em_afe_pkg::DIV_DW-1:0] dsr_q;
  logic [em_afe_pkg::DIV_NW-1:0] dq_q;

  logic [em_afe_pkg::DIV_DW:0]   sh;
  logic                          qbit;
  logic [em_afe_pkg::DIV_DW:0]   diff;

  always_comb begin
    sh   = {rem_q, dq_q[em_afe_pkg::DIV_NW-1]};
    qbit = (sh >= {1'b0, dsr_q});
    diff = sh - {1'b0, dsr_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= em_afe_pkg::DIV_CW'(em_afe_pkg::DIV_NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == em_afe_pkg::DIV_CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dsr_q <= divisor_i;
      dq_q  <= dividend_i;
    end else if (busy_q) begin
      rem_q <= qbit ? diff[em_afe_pkg::DIV_DW-1:0] : sh[em_afe_pkg::DIV_DW-1:0];
      dq_q  <= {dq_q[em_afe_pkg::DIV_NW-2:0], qbit};
    end
  end

  assign done_o = done_q;
  assign quot_o = (dsr_q == '0) ? '0 : dq_q;

endmodule
`default_nettype wire

FILE: design/em_afe_term.sv
`default_nettype none
// Per-individual EM term: floor(65536*num/den), all ones if num >= den,
// zero if den is zero; one shared multiplier, then a 16-step fraction divider.
module em_afe_term (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire em_afe_pkg::term_cmd_t             cmd_i,
  input  wire logic [em_afe_pkg::FREQ_W-1:0]     p_i,
  input  wire logic [em_afe_pkg::ENTRY_W-1:0]    entry_i,
  output em_afe_pkg::term_sts_t                  sts_o
);

  em_afe_pkg::term_st_e state_q, state_d;
  logic [3:0]  step_q, step_d;
  logic        done_q, done_d;

  logic [31:0]                      pp_q, pq_q;
  logic [32:0]                      qq_q;
  logic [em_afe_pkg::PROD_W-1:0]    pa_q, pb_q, pc_q;
  logic [em_afe_pkg::TERM_W-1:0]    den_q, r_q;
  logic [em_afe_pkg::FREQ_W-1:0]    quo_q;

  logic [16:0]                      q;
  logic [em_afe_pkg::MUL_AW-1:0]    mul_a;
  logic [em_afe_pkg::MUL_BW-1:0]    mul_b;
  logic [em_afe_pkg::PROD_W-1:0]    prod;
  logic [em_afe_pkg::TERM_W-1:0]    num, den;
  logic [em_afe_pkg::TERM_W-1:0]    pb2;
  logic [em_afe_pkg::TERM_W:0]      r2;
  logic [em_afe_pkg::TERM_W:0]      r2_sub;
  logic                             qbit;

  assign q = 17'h10000 - {1'b0, p_i};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      em_afe_pkg::T_COEF: begin
        case (step_q[1:0])
          2'd0: begin mul_a = {17'b0, p_i}; mul_b = {1'b0, p_i}; end
          2'd1: begin mul_a = {17'b0, p_i}; mul_b = q; end
          default: begin mul_a = {16'b0, q}; mul_b = q; end
        endcase
      end
      em_afe_pkg::T_MUL: begin
        case (step_q[1:0])
          2'd0: begin mul_a = qq_q; mul_b = {1'b0, entry_i[15:0]}; end
          2'd1: begin mul_a = {1'b0, pq_q}; mul_b = {1'b0, entry_i[31:16]}; end
          default: begin mul_a = {1'b0, pp_q}; mul_b = {1'b0, entry_i[47:32]}; end
        endcase
      end
      default: ;
    endcase
  end

  assign prod   = mul_a * mul_b;
  assign num    = em_afe_pkg::TERM_W'(pb_q) + em_afe_pkg::TERM_W'(pc_q);
  assign pb2    = em_afe_pkg::TERM_W'({pb_q, 1'b0});
  assign den    = em_afe_pkg::TERM_W'(pa_q) + pb2 + em_afe_pkg::TERM_W'(pc_q);
  assign r2     = {r_q, 1'b0};
  assign r2_sub = r2 - {1'b0, den_q};
  assign qbit   = (r2 >= {1'b0, den_q});

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    done_d  = 1'b0;
    case (state_q)
      em_afe_pkg::T_IDLE: begin
        step_d = '0;
        if (cmd_i.coef) state_d = em_afe_pkg::T_COEF;
        else if (cmd_i.item) state_d = em_afe_pkg::T_MUL;
      end
      em_afe_pkg::T_COEF: begin
        step_d = step_q + 1'b1;
        if (step_q == 4'd2) begin
          state_d = em_afe_pkg::T_IDLE;
          done_d  = 1'b1;
        end
      end
      em_afe_pkg::T_MUL: begin
        step_d = step_q + 1'b1;
        if (step_q == 4'd2) state_d = em_afe_pkg::T_SUM;
      end
      em_afe_pkg::T_SUM: begin
        step_d = '0;
        if (den == '0 || num >= den) begin
          state_d = em_afe_pkg::T_IDLE;
          done_d  = 1'b1;
        end else begin
          state_d = em_afe_pkg::T_DIV;
        end
      end
      em_afe_pkg::T_DIV: begin
        step_d = step_q + 1'b1;
        if (step_q == 4'd15) begin
          state_d = em_afe_pkg::T_IDLE;
          done_d  = 1'b1;
        end
      end
      default: state_d = em_afe_pkg::T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= em_afe_pkg::T_IDLE;
      step_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      em_afe_pkg::T_COEF: begin
        case (step_q[1:0])
          2'd0: pp_q <= prod[31:0];
          2'd1: pq_q <= prod[31:0];
          default: qq_q <= prod[32:0];
        endcase
      end
      em_afe_pkg::T_MUL: begin
        case (step_q[1:0])
          2'd0: pa_q <= prod;
          2'd1: pb_q <= prod;
          default: pc_q <= prod;
        endcase
      end
      em_afe_pkg::T_SUM: begin
        den_q <= den;
        r_q   <= num;
        if (den == '0) quo_q <= '0;
        else if (num >= den) quo_q <= '1;
        else quo_q <= '0;
      end
      em_afe_pkg::T_DIV: begin
        r_q   <= qbit ? r2_sub[em_afe_pkg::TERM_W-1:0] : r2[em_afe_pkg::TERM_W-1:0];
        quo_q <= {quo_q[em_afe_pkg::FREQ_W-2:0], qbit};
      end
      default: ;
    endcase
  end

  assign sts_o.done = done_q;
  assign sts_o.term = quo_q;

endmodule
`default_nettype wire

FILE: design/em_allele_frequency_estimator_unit.sv
`default_nettype none
// Alt-allele frequency estimator, one locus at a time.
// Input channel (in_valid_i / in_stall_o): one transaction per individual
// carrying its three Q0.16 genotype likelihoods; last_individual_i closes the
// locus. Loading takes one cycle per individual; up to 1024 are stored in an
// on-chip likelihood RAM, later ones are dropped but a closing mark still counts.
// After the closing transaction in_stall_o stays high while the locus is
// estimated: a point-estimate division, then EM passes. Each pass forms
// the coefficients, then for each individual a RAM read, three products on
// the shared multiplier and the 16-step term divider; the long divider then
// forms each pass mean.
// Output channel (out_valid_o / out_stall_i): one transaction per locus, held
// in an output register. While it is stalled the next locus may still load;
// its estimation finishes and then waits until the register frees up.
// Configuration (tolerance, max_iterations) is written through cfg_we_i and
// must only change while the block is idle. Reset (rst_ni low) clears the
// locus state and restores tolerance 66 and max_iterations 20; RAM contents
// are not cleared and only entries of the current locus are read.
module em_allele_frequency_estimator_unit (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic                            cfg_idx_i,
  input  wire logic [em_afe_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [em_afe_pkg::LIK_W-1:0]    lik_hom_ref_i,
  input  wire logic [em_afe_pkg::LIK_W-1:0]    lik_het_i,
  input  wire logic [em_afe_pkg::LIK_W-1:0]    lik_hom_alt_i,
  input  wire logic                            last_individual_i,
  input  wire logic [em_afe_pkg::TAG_W-1:0]    locus_tag_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic      [em_afe_pkg::TAG_W-1:0]    result_locus_o,
  output logic      [em_afe_pkg::FREQ_W-1:0]   initial_frequency_o,
  output logic      [em_afe_pkg::FREQ_W-1:0]   em_frequency_o,
  output logic      [em_afe_pkg::ITER_W-1:0]   iterations_used_o,
  output logic                                 converged_o
);

  em_afe_pkg::st_e state_q, state_d;

  logic [em_afe_pkg::FREQ_W-1:0]  tol_q;
  logic [em_afe_pkg::ITER_W-1:0]  maxit_q;
  logic [em_afe_pkg::CNT_W-1:0]   count_q, j_q;
  logic [em_afe_pkg::DIV_NW-1:0]  sum_q, mean_q;
  logic [em_afe_pkg::FREQ_W-1:0]  freq_q, init_q;
  logic [em_afe_pkg::ITER_W-1:0]  pass_q;
  logic [em_afe_pkg::FREQ_W:0]    change_q;
  logic [em_afe_pkg::TAG_W-1:0]   tag_q;
  logic                           out_valid_q;

  logic                           in_acc;
  logic [em_afe_pkg::LIK_W-1:0]   l0, l1, l2;
  logic                           store_ok;
  logic                           ram_re;
  logic [em_afe_pkg::ENTRY_W-1:0] ram_rdata;

  logic                           div_start, div_done;
  logic [em_afe_pkg::DIV_NW-1:0]  div_dividend, div_quot;
  logic [em_afe_pkg::DIV_DW-1:0]  div_divisor;
  logic [em_afe_pkg::FREQ_W-1:0]  div_sat;

  em_afe_pkg::term_cmd_t          term_cmd;
  em_afe_pkg::term_sts_t          term_sts;

  logic                           run_pass;
  logic                           out_free;

  assign in_stall_o = (state_q != em_afe_pkg::S_LOAD);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign l0 = (lik_hom_ref_i == '0) ? em_afe_pkg::LIK_W'(1) : lik_hom_ref_i;
  assign l1 = (lik_het_i == '0) ? em_afe_pkg::LIK_W'(1) : lik_het_i;
  assign l2 = (lik_hom_alt_i == '0) ? em_afe_pkg::LIK_W'(1) : lik_hom_alt_i;
  assign store_ok = !count_q[em_afe_pkg::CNT_W-1];
  assign out_free = !out_valid_q || !out_stall_i;
  assign run_pass = (pass_q < maxit_q) && (change_q > {1'b0, tol_q});
  assign div_sat  = em_afe_pkg::sat16(div_quot);

  em_afe_ram #(
    .Width (em_afe_pkg::ENTRY_W),
    .Depth (em_afe_pkg::MAX_INDIVIDUALS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (in_acc && store_ok),
    .waddr_i (count_q[em_afe_pkg::ADDR_W-1:0]),
    .wdata_i ({l2, l1, l0}),
    .re_i    (ram_re),
    .raddr_i (j_q[em_afe_pkg::ADDR_W-1:0]),
    .rdata_o (ram_rdata)
  );

  em_afe_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  em_afe_term u_term (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (term_cmd),
    .p_i     (freq_q),
    .entry_i (ram_rdata),
    .sts_o   (term_sts)
  );

  always_comb begin
    state_d      = state_q;
    ram_re       = 1'b0;
    div_start    = 1'b0;
    div_dividend = mean_q;
    div_divisor  = {1'b0, count_q};
    term_cmd     = '0;
    case (state_q)
      em_afe_pkg::S_LOAD: begin
        if (in_acc && last_individual_i) state_d = em_afe_pkg::S_PSTART;
      end
      em_afe_pkg::S_PSTART: begin
        div_start    = 1'b1;
        div_dividend = sum_q;
        div_divisor  = {count_q, 1'b0};
        state_d      = em_afe_pkg::S_PWAIT;
      end
      em_afe_pkg::S_PWAIT: begin
        if (div_done) state_d = em_afe_pkg::S_CHECK;
      end
      em_afe_pkg::S_CHECK: begin
        if (run_pass) begin
          term_cmd.coef = 1'b1;
          state_d       = em_afe_pkg::S_COEF;
        end else begin
          state_d = em_afe_pkg::S_DONE;
        end
      end
      em_afe_pkg::S_COEF: begin
        if (term_sts.done) begin
          state_d = (count_q == '0) ? em_afe_pkg::S_MSTART : em_afe_pkg::S_RD;
        end
      end
      em_afe_pkg::S_RD: begin
        ram_re  = 1'b1;
        state_d = em_afe_pkg::S_ISTART;
      end
      em_afe_pkg::S_ISTART: begin
        term_cmd.item = 1'b1;
        state_d       = em_afe_pkg::S_IWAIT;
      end
      em_afe_pkg::S_IWAIT: begin
        if (term_sts.done) begin
          state_d = (j_q + 1'b1 == count_q) ? em_afe_pkg::S_MSTART : em_afe_pkg::S_RD;
        end
      end
      em_afe_pkg::S_MSTART: begin
        div_start = 1'b1;
        state_d   = em_afe_pkg::S_MWAIT;
      end
      em_afe_pkg::S_MWAIT: begin
        if (div_done) state_d = em_afe_pkg::S_CHECK;
      end
      em_afe_pkg::S_DONE: begin
        if (out_free) state_d = em_afe_pkg::S_LOAD;
      end
      default: state_d = em_afe_pkg::S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= em_afe_pkg::S_LOAD;
      tol_q       <= em_afe_pkg::FREQ_W'(66);
      maxit_q     <= em_afe_pkg::ITER_W'(20);
      count_q     <= '0;
      sum_q       <= '0;
      freq_q      <= '0;
      mean_q      <= '0;
      pass_q      <= '0;
      change_q    <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (em_afe_pkg::cfg_reg_e'(cfg_idx_i))
          em_afe_pkg::REG_TOLERANCE: tol_q   <= cfg_wdata_i;
          em_afe_pkg::REG_MAX_ITER:  maxit_q <= cfg_wdata_i[em_afe_pkg::ITER_W-1:0];
          default: ;
        endcase
      end
      if (state_q == em_afe_pkg::S_DONE && out_free) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      case (state_q)
        em_afe_pkg::S_LOAD: begin
          if (in_acc && store_ok) begin
            count_q <= count_q + 1'b1;
            sum_q   <= sum_q + em_afe_pkg::DIV_NW'(l1) + em_afe_pkg::DIV_NW'({l2, 1'b0});
          end
        end
        em_afe_pkg::S_PWAIT: begin
          if (div_done) begin
            freq_q   <= div_sat;
            change_q <= {1'b1, {em_afe_pkg::FREQ_W{1'b0}}};
          end
        end
        em_afe_pkg::S_CHECK: begin
          mean_q <= '0;
          j_q    <= '0;
        end
        em_afe_pkg::S_IWAIT: begin
          if (term_sts.done) begin
            mean_q <= mean_q + em_afe_pkg::DIV_NW'(term_sts.term);
            j_q    <= j_q + 1'b1;
          end
        end
        em_afe_pkg::S_MWAIT: begin
          if (div_done) begin
            freq_q   <= div_sat;
            change_q <= (div_sat >= freq_q) ? {1'b0, div_sat - freq_q}
                                            : {1'b0, freq_q - div_sat};
            pass_q   <= pass_q + 1'b1;
          end
        end
        em_afe_pkg::S_DONE: begin
          if (out_free) begin
            count_q     <= '0;
            sum_q       <= '0;
            freq_q      <= '0;
            mean_q      <= '0;
            pass_q      <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && last_individual_i) tag_q <= locus_tag_i;
    if (state_q == em_afe_pkg::S_PWAIT && div_done) init_q <= div_sat;
    if (state_q == em_afe_pkg::S_DONE && out_free) begin
      result_locus_o      <= tag_q;
      initial_frequency_o <= init_q;
      em_frequency_o      <= freq_q;
      iterations_used_o   <= pass_q;
      converged_o         <= (pass_q != '0) && (change_q <= {1'b0, tol_q});
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire
